// File: rtl/aptp_pkg.sv
// ----------------------------------------------------------------------------
// aptp_pkg
// Shared types and codes of the aging-priority task picker.
// ----------------------------------------------------------------------------
package aptp_pkg;

    localparam int SLOT_FW   = 4;
    localparam int PRIO_W    = 3;
    localparam int WEIGHT_W  = 8;
    localparam int PROD_W    = PRIO_W + WEIGHT_W;
    localparam int SCORE_W   = 17;
    localparam int STATUS_W  = 2;

    localparam logic [SCORE_W-1:0] SCORE_MAX = 17'h1FFFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 8'd10;

    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_CREATE = 2'd1;
    localparam logic [1:0] REQ_STATUS = 2'd2;
    localparam logic [1:0] REQ_FREE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_READY   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RUNNING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BLOCKED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FINAL   = 2'd3;

    localparam logic [1:0] RES_OK    = 2'd0;
    localparam logic [1:0] RES_NONE  = 2'd1;
    localparam logic [1:0] RES_FULL  = 2'd2;
    localparam logic [1:0] RES_EMPTY = 2'd3;

    localparam logic CFG_USE_PRIORITY    = 1'b0;
    localparam logic CFG_PRIORITY_WEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [SLOT_FW-1:0]  slot;
        logic [PRIO_W-1:0]   priority_req;
        logic [STATUS_W-1:0] new_status;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         result_code;
        logic [SLOT_FW-1:0] chosen_slot;
        logic [SCORE_W-1:0] chosen_score;
    } t_out_item;

    typedef enum logic [2:0] {
        RK_TICK,
        RK_CREATE,
        RK_FULL,
        RK_EMPTY,
        RK_OK
    } t_res_kind;

    typedef struct packed {
        logic      load;
        logic      cnt_clr;
        logic      cnt_inc;
        logic      best_clr;
        logic      scan_rd;
        logic      scan_eval;
        logic      tgt_rd;
        logic      create_wr;
        logic      stat_wr;
        logic      win_wr;
        logic      free;
        logic      res_load;
        t_res_kind res_kind;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req;
        logic       cnt_last;
        logic       cnt_used;
        logic       tgt_bad;
    } t_stat;

endpackage

// File: rtl/aptp_ram.sv
// ----------------------------------------------------------------------------
// aptp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aptp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/aptp_datapath.sv
// ----------------------------------------------------------------------------
// aptp_datapath
// Slot table, scan counter, score unit, winner tracking and result registers.
// ----------------------------------------------------------------------------
module aptp_datapath #(
    parameter int SLOTS    = 16,
    parameter int AGE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  aptp_pkg::t_in_item          i_item,
    input  aptp_pkg::t_cmd              i_cmd,
    output aptp_pkg::t_stat             o_stat,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [aptp_pkg::WEIGHT_W-1:0] i_cfg_data,
    output aptp_pkg::t_out_item         o_out_item
);

    localparam int SW    = $clog2(SLOTS);
    localparam int EXT_W = SW + aptp_pkg::SLOT_FW;
    localparam int DW    = aptp_pkg::STATUS_W + aptp_pkg::PRIO_W + AGE_BITS;
    localparam int SCW   = ((AGE_BITS > aptp_pkg::PROD_W) ? AGE_BITS : aptp_pkg::PROD_W) + 1;
    localparam int WW    = (SCW > aptp_pkg::SCORE_W) ? SCW : aptp_pkg::SCORE_W;

    aptp_pkg::t_in_item            r_item;
    logic [SLOTS-1:0]              r_used;
    logic [SW-1:0]                 r_cnt;
    logic [SW-1:0]                 r_ev_idx;
    logic                          r_ev_used;
    logic [SCW-1:0]                r_best;
    logic [SW-1:0]                 r_win;
    logic [aptp_pkg::PRIO_W-1:0]   r_win_prio;
    logic                          r_found;
    logic                          r_use_pri;
    logic [aptp_pkg::WEIGHT_W-1:0] r_weight;
    aptp_pkg::t_out_item           r_res;
    aptp_pkg::t_out_item           r_out;

    logic [EXT_W-1:0]              tgt_ext;
    logic [SW-1:0]                 tgt_idx;
    logic                          tgt_ok;
    logic [DW-1:0]                 rdata;
    logic [aptp_pkg::STATUS_W-1:0] rd_st;
    logic [aptp_pkg::PRIO_W-1:0]   rd_pr;
    logic [AGE_BITS-1:0]           rd_age;
    logic [AGE_BITS-1:0]           age_n;
    logic [aptp_pkg::PROD_W-1:0]   prod;
    logic [SCW-1:0]                score;
    logic                          elig;
    logic                          fin;
    logic                          beats;
    logic                          we;
    logic [SW-1:0]                 waddr;
    logic [DW-1:0]                 wdata;
    logic [SW-1:0]                 raddr;
    logic [WW-1:0]                 best_w;
    logic [aptp_pkg::SCORE_W-1:0]  best_sat;
    logic [EXT_W-1:0]              win_ext;
    logic [EXT_W-1:0]              cnt_ext;
    aptp_pkg::t_out_item           res_n;

    assign tgt_ext = EXT_W'(r_item.slot);
    assign tgt_idx = tgt_ext[SW-1:0];
    assign tgt_ok  = (tgt_ext < EXT_W'(SLOTS)) && r_used[tgt_idx];

    assign o_stat.req      = r_item.req_type;
    assign o_stat.cnt_last = (r_cnt == SW'(SLOTS - 1));
    assign o_stat.cnt_used = r_used[r_cnt];
    assign o_stat.tgt_bad  = !tgt_ok;

    assign rd_st  = rdata[DW-1 -: aptp_pkg::STATUS_W];
    assign rd_pr  = rdata[AGE_BITS +: aptp_pkg::PRIO_W];
    assign rd_age = rdata[AGE_BITS-1:0];

    assign elig  = r_ev_used && (rd_st != aptp_pkg::ST_FINAL) &&
                   (rd_st != aptp_pkg::ST_BLOCKED) && (rd_pr != '0);
    assign fin   = r_ev_used && (rd_st == aptp_pkg::ST_FINAL);
    assign age_n = (&rd_age) ? rd_age : rd_age + AGE_BITS'(1);
    assign prod  = aptp_pkg::PROD_W'(rd_pr) * aptp_pkg::PROD_W'(r_weight);
    assign score = SCW'(age_n) + (r_use_pri ? SCW'(prod) : SCW'(0));
    assign beats = elig && (score > r_best);

    always_comb begin
        we    = 1'b0;
        waddr = r_ev_idx;
        wdata = {rd_st, rd_pr, age_n};
        if (i_cmd.scan_eval && elig) begin
            we = 1'b1;
        end else if (i_cmd.create_wr) begin
            we    = 1'b1;
            waddr = r_cnt;
            wdata = {r_item.new_status, r_item.priority_req, AGE_BITS'(0)};
        end else if (i_cmd.stat_wr) begin
            we    = 1'b1;
            waddr = tgt_idx;
            wdata = {r_item.new_status, rd_pr, rd_age};
        end else if (i_cmd.win_wr && r_found) begin
            we    = 1'b1;
            waddr = r_win;
            wdata = {aptp_pkg::ST_RUNNING, r_win_prio, AGE_BITS'(0)};
        end
    end

    assign raddr = i_cmd.scan_rd ? r_cnt : tgt_idx;

    aptp_ram #(
        .WIDTH (DW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.scan_rd || i_cmd.tgt_rd),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign best_w   = WW'(r_best);
    assign best_sat = (best_w > WW'(aptp_pkg::SCORE_MAX)) ? aptp_pkg::SCORE_MAX
                                                         : best_w[aptp_pkg::SCORE_W-1:0];
    assign win_ext  = EXT_W'(r_win);
    assign cnt_ext  = EXT_W'(r_cnt);

    always_comb begin
        res_n = '0;
        case (i_cmd.res_kind)
            aptp_pkg::RK_TICK: begin
                if (r_found) begin
                    res_n.result_code  = aptp_pkg::RES_OK;
                    res_n.chosen_slot  = win_ext[aptp_pkg::SLOT_FW-1:0];
                    res_n.chosen_score = best_sat;
                end else begin
                    res_n.result_code = aptp_pkg::RES_NONE;
                end
            end
            aptp_pkg::RK_CREATE: begin
                res_n.result_code = aptp_pkg::RES_OK;
                res_n.chosen_slot = cnt_ext[aptp_pkg::SLOT_FW-1:0];
            end
            aptp_pkg::RK_FULL:  res_n.result_code = aptp_pkg::RES_FULL;
            aptp_pkg::RK_EMPTY: res_n.result_code = aptp_pkg::RES_EMPTY;
            aptp_pkg::RK_OK:    res_n.result_code = aptp_pkg::RES_OK;
            default:            res_n = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_use_pri <= 1'b1;
            r_weight  <= aptp_pkg::WEIGHT_RST;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == aptp_pkg::CFG_USE_PRIORITY) begin
                    r_use_pri <= i_cfg_data[0];
                end else begin
                    r_weight <= i_cfg_data;
                end
            end
            if (i_cmd.scan_eval && fin) begin
                r_used[r_ev_idx] <= 1'b0;
            end
            if (i_cmd.create_wr) begin
                r_used[r_cnt] <= 1'b1;
            end
            if (i_cmd.free) begin
                r_used[tgt_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + SW'(1);
        end
        if (i_cmd.scan_rd) begin
            r_ev_idx  <= r_cnt;
            r_ev_used <= r_used[r_cnt];
        end
        if (i_cmd.best_clr) begin
            r_best  <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.scan_eval && beats) begin
            r_best     <= score;
            r_win      <= r_ev_idx;
            r_win_prio <= rd_pr;
            r_found    <= 1'b1;
        end
        if (i_cmd.res_load) begin
            r_res <= res_n;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_item = r_out;

endmodule

// File: rtl/aptp_ctrl.sv
// ----------------------------------------------------------------------------
// aptp_ctrl
// Request sequencer: accepts items, steps the slot scan, hands off results.
// ----------------------------------------------------------------------------
module aptp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_req_type,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  aptp_pkg::t_stat i_stat,
    output aptp_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TK_FIRST,
        S_TK_RUN,
        S_TK_TAIL,
        S_TK_WIN,
        S_CR_SCAN,
        S_CHK,
        S_ST_WR,
        S_DONE
    } t_state;

    t_state         r_state;
    t_state         n_state;
    logic           r_out_valid;
    logic           n_out_valid;
    aptp_pkg::t_cmd cmd;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        cmd         = '0;
        cmd.res_kind = aptp_pkg::RK_OK;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load     = 1'b1;
                    cmd.cnt_clr  = 1'b1;
                    cmd.best_clr = 1'b1;
                    case (i_req_type)
                        aptp_pkg::REQ_TICK:   n_state = S_TK_FIRST;
                        aptp_pkg::REQ_CREATE: n_state = S_CR_SCAN;
                        default:              n_state = S_CHK;
                    endcase
                end
            end
            S_TK_FIRST, S_TK_RUN: begin
                cmd.scan_rd   = 1'b1;
                cmd.scan_eval = (r_state == S_TK_RUN);
                if (i_stat.cnt_last) begin
                    n_state = S_TK_TAIL;
                end else begin
                    cmd.cnt_inc = 1'b1;
                    n_state     = S_TK_RUN;
                end
            end
            S_TK_TAIL: begin
                cmd.scan_eval = 1'b1;
                n_state       = S_TK_WIN;
            end
            S_TK_WIN: begin
                cmd.win_wr   = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_kind = aptp_pkg::RK_TICK;
                n_state      = S_DONE;
            end
            S_CR_SCAN: begin
                if (!i_stat.cnt_used) begin
                    cmd.create_wr = 1'b1;
                    cmd.res_load  = 1'b1;
                    cmd.res_kind  = aptp_pkg::RK_CREATE;
                    n_state       = S_DONE;
                end else if (i_stat.cnt_last) begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = aptp_pkg::RK_FULL;
                    n_state      = S_DONE;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            S_CHK: begin
                if (i_stat.tgt_bad) begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = aptp_pkg::RK_EMPTY;
                    n_state      = S_DONE;
                end else if (i_stat.req == aptp_pkg::REQ_FREE) begin
                    cmd.free     = 1'b1;
                    cmd.res_load = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    cmd.tgt_rd = 1'b1;
                    n_state    = S_ST_WR;
                end
            end
            S_ST_WR: begin
                cmd.stat_wr  = 1'b1;
                cmd.res_load = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// File: rtl/aging_priority_task_picker_unit.sv
// ----------------------------------------------------------------------------
// aging_priority_task_picker_unit
// Task slot table with create, set-status, free and an aging-priority pick.
// ----------------------------------------------------------------------------
// One request is in work at a time. A tick scans the slot table through a
// registered-read RAM one slot per cycle and then marks the winner, if any,
// running. A create searches the used bits one slot per cycle until it finds
// a free slot or reaches the last one; set status reads the slot and then
// writes it, and free clears the used bit. A result waiting at the output
// does not block the next accept. The configuration port is always ready.
module aging_priority_task_picker_unit #(
    parameter int SLOTS    = 16,
    parameter int AGE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  aptp_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output aptp_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [aptp_pkg::WEIGHT_W-1:0] i_cfg_data
);

    aptp_pkg::t_cmd  cmd;
    aptp_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    aptp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_in_item.req_type),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    aptp_datapath #(
        .SLOTS    (SLOTS),
        .AGE_BITS (AGE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_item  (o_out_item)
    );

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("accepted item did not make the block busy");

    a_one_table_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.scan_eval, cmd.create_wr, cmd.stat_wr, cmd.win_wr}))
        else $error("conflicting slot table writes");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("result loaded over a pending item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule
